### rtl/dbd_pkg.sv
// ----------------------------------------------------------------------------
// dbd_pkg
// Shared widths, constants and the month table for the date difference block.
// ----------------------------------------------------------------------------
`default_nettype none

package dbd_pkg;

  localparam int unsigned YearW  = 14;
  localparam int unsigned MonthW = 4;
  localparam int unsigned DayW   = 5;
  localparam int unsigned DiffW  = 23;

  // Day number width: the largest value for a 14-bit year fits 23 bits.
  localparam int unsigned DayNumW = 23;

  localparam int unsigned DaysPerYear = 365;

  // x / 25 == (x * Recip25) >> Recip25Shift for x below 43690
  localparam int unsigned Recip25      = 5243;
  localparam int unsigned Recip25Shift = 17;
  localparam int unsigned Div25        = 25;

  localparam int unsigned MonthIdxW = 4;
  localparam int unsigned DbmW      = 9;

  // Stage enables handed from the flow control to the lanes
  typedef struct packed {
    logic en1;
    logic en2;
  } lane_en_t;

  // Days in the months of a common year that come before the given month.
  function automatic logic [DbmW-1:0] days_before_month(input logic [MonthIdxW-1:0] idx);
    logic [DbmW-1:0] r;
    case (idx)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd31;
      4'd2:    r = 9'd59;
      4'd3:    r = 9'd90;
      4'd4:    r = 9'd120;
      4'd5:    r = 9'd151;
      4'd6:    r = 9'd181;
      4'd7:    r = 9'd212;
      4'd8:    r = 9'd243;
      4'd9:    r = 9'd273;
      4'd10:   r = 9'd304;
      default: r = 9'd334;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/days_between_dates.sv
// ----------------------------------------------------------------------------
// days_between_dates
// Days from a start date to an end date in the proleptic Gregorian calendar.
// ----------------------------------------------------------------------------
// One transaction carries a date pair; one result transaction carries the
// signed day count (end minus start, two's complement, modulo 2^23). A new
// pair is taken every cycle while the output side keeps up; between input
// and output lie two lane stages (products, then sum) and the merge register,
// which doubles as the output register. Back-pressure
// stalls each stage only when it holds data that cannot move on, so holes in
// the stream are squeezed out. Dates are not validated: month 0 counts as
// January, months 13 to 15 as December, and the day is added as given.
// ----------------------------------------------------------------------------
`default_nettype none

module days_between_dates (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  // [13:0] start_year, [17:14] start_month, [22:18] start_day,
  // [36:23] end_year, [40:37] end_month, [45:41] end_day, [47:46] zero
  input  wire  [47:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  // [22:0] day_difference, [23] zero
  output logic [23:0] m_axis_tdata
);

  // Pipeline occupancy: stage 1, stage 2, output register
  logic v1_q, v2_q, v3_q;
  logic rdy1, rdy2, rdy3;
  dbd_pkg::lane_en_t lane_en;

  // a stage may load when empty or when its content moves on this cycle
  assign rdy3 = !v3_q || m_axis_tready;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;

  assign s_axis_tready = rdy1;
  assign lane_en.en1   = rdy1 && s_axis_tvalid;
  assign lane_en.en2   = rdy2 && v1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_q <= s_axis_tvalid;
      end
      if (rdy2) begin
        v2_q <= v1_q;
      end
      if (rdy3) begin
        v3_q <= v2_q;
      end
    end
  end

  // Two lanes, one per date
  logic [dbd_pkg::DayNumW-1:0] start_num, end_num;

  dbd_lane u_lane_start (
    .clk_i     (clk_i),
    .en_i      (lane_en),
    .year_i    (s_axis_tdata[13:0]),
    .month_i   (s_axis_tdata[17:14]),
    .day_i     (s_axis_tdata[22:18]),
    .day_num_o (start_num)
  );

  dbd_lane u_lane_end (
    .clk_i     (clk_i),
    .en_i      (lane_en),
    .year_i    (s_axis_tdata[36:23]),
    .month_i   (s_axis_tdata[40:37]),
    .day_i     (s_axis_tdata[45:41]),
    .day_num_o (end_num)
  );

  // Merge: subtract and hold for the output side
  logic [dbd_pkg::DiffW-1:0] diff;

  dbd_merge u_merge (
    .clk_i       (clk_i),
    .en_i        (rdy3 && v2_q),
    .start_num_i (start_num),
    .end_num_i   (end_num),
    .diff_o      (diff)
  );

  assign m_axis_tvalid = v3_q;
  assign m_axis_tdata  = {1'b0, diff};

`ifndef SYNTHESIS
  // an accepted transaction lands in stage 1
  a_accept_fills_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> v1_q)
    else $error("accepted transaction not held in stage 1");

  // stage 1 content moving on reaches stage 2
  a_s1_to_s2: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q && rdy2) |=> v2_q)
    else $error("stage 1 content lost on its way to stage 2");

  // a blocked stage 2 keeps its content
  a_s2_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v2_q && !rdy3) |=> v2_q)
    else $error("stalled stage 2 dropped its content");

  // stage 2 never advances into a full output register that is not drained
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v3_q && !m_axis_tready) |-> !(rdy3 && v2_q))
    else $error("output register overwritten while stalled");
`endif

endmodule

`default_nettype wire

### rtl/dbd_lane.sv
// ----------------------------------------------------------------------------
// dbd_lane
// Day number of one date, counted from the start of year 0, in two stages.
// ----------------------------------------------------------------------------
`default_nettype none

module dbd_lane (
  input  wire                              clk_i,
  input  wire dbd_pkg::lane_en_t           en_i,
  input  wire [dbd_pkg::YearW-1:0]         year_i,
  input  wire [dbd_pkg::MonthW-1:0]        month_i,
  input  wire [dbd_pkg::DayW-1:0]          day_i,
  output logic [dbd_pkg::DayNumW-1:0]      day_num_o
);

  localparam int unsigned NW = dbd_pkg::DayNumW;

  // stage 1: products and ceilings
  logic [14:0] y_p3, y_p99, y_p399;
  logic [12:0] c4_d, a100;
  logic [10:0] a400;
  logic [11:0] t_d;
  logic [9:0]  u_d;
  logic [25:0] p100;
  logic [23:0] p400;
  logic [24:0] pt;
  logic [22:0] pu;
  logic [3:0]  midx;
  logic [NW-1:0] yd_d;

  logic [NW-1:0]            yd_q;
  logic [12:0]              c4_q;
  logic [7:0]               q100_q;
  logic [5:0]               q400_q;
  logic [dbd_pkg::DbmW-1:0] dbm_q;
  logic                     late_q;
  logic [dbd_pkg::DayW-1:0] day_q;
  logic [11:0]              t_q;
  logic [7:0]               qt_q;
  logic [9:0]               u_q;
  logic [5:0]               qu_q;
  logic                     y4z_q, y16z_q;

  always_comb begin
    y_p3   = {1'b0, year_i} + 15'd3;
    y_p99  = {1'b0, year_i} + 15'd99;
    y_p399 = {1'b0, year_i} + 15'd399;
    c4_d   = y_p3[14:2];
    a100   = y_p99[14:2];
    a400   = y_p399[14:4];
    t_d    = year_i[13:2];
    u_d    = year_i[13:4];
    p100   = 26'(a100) * 26'(dbd_pkg::Recip25);
    p400   = 24'(a400) * 24'(dbd_pkg::Recip25);
    pt     = 25'(t_d) * 25'(dbd_pkg::Recip25);
    pu     = 23'(u_d) * 23'(dbd_pkg::Recip25);
    yd_d   = NW'(year_i) * NW'(dbd_pkg::DaysPerYear);
    // month 0 counts as January, 13 to 15 as December
    if (month_i == 4'd0) begin
      midx = 4'd0;
    end else if (month_i > 4'd12) begin
      midx = 4'd11;
    end else begin
      midx = month_i - 4'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.en1) begin
      yd_q   <= yd_d;
      c4_q   <= c4_d;
      q100_q <= p100[24:17];
      q400_q <= p400[22:17];
      dbm_q  <= dbd_pkg::days_before_month(midx);
      late_q <= (month_i > 4'd2);
      day_q  <= day_i;
      t_q    <= t_d;
      qt_q   <= pt[24:17];
      u_q    <= u_d;
      qu_q   <= pu[22:17];
      y4z_q  <= (year_i[1:0] == 2'd0);
      y16z_q <= (year_i[3:0] == 4'd0);
    end
  end

  // stage 2: leap test and sum
  logic [11:0]   qt25;
  logic [9:0]    qu25;
  logic          is100, is400, leap;
  logic [NW-1:0] n_d;

  always_comb begin
    qt25  = 12'(12'(qt_q) * 12'(dbd_pkg::Div25));
    qu25  = 10'(10'(qu_q) * 10'(dbd_pkg::Div25));
    is100 = y4z_q && (t_q == qt25);
    is400 = y16z_q && (u_q == qu25);
    leap  = y4z_q && (!is100 || is400);
    n_d   = yd_q + NW'(c4_q) - NW'(q100_q) + NW'(q400_q) + NW'(dbm_q)
          + NW'(late_q && leap) + NW'(day_q);
  end

  always_ff @(posedge clk_i) begin
    if (en_i.en2) begin
      day_num_o <= n_d;
    end
  end

endmodule

`default_nettype wire

### rtl/dbd_merge.sv
// ----------------------------------------------------------------------------
// dbd_merge
// Combines the two lanes: end day number minus start day number, registered.
// ----------------------------------------------------------------------------
`default_nettype none

module dbd_merge (
  input  wire                           clk_i,
  input  wire                           en_i,
  input  wire  [dbd_pkg::DayNumW-1:0]   start_num_i,
  input  wire  [dbd_pkg::DayNumW-1:0]   end_num_i,
  output logic [dbd_pkg::DiffW-1:0]     diff_o
);

  logic [dbd_pkg::DiffW-1:0] diff_d;

  // wraps modulo 2^23, negative when the end date is earlier
  assign diff_d = dbd_pkg::DiffW'(end_num_i - start_num_i);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      diff_o <= diff_d;
    end
  end

endmodule

`default_nettype wire

### tb/dbd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbd_checker
// Watches both stream channels of the date difference block, predicts each
// day count from the accepted date pair and compares it with the result.
// ----------------------------------------------------------------------------
module dbd_checker (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        s_axis_tvalid,
  input  wire        s_axis_tready,
  input  wire [47:0] s_axis_tdata,
  input  wire        m_axis_tvalid,
  input  wire        m_axis_tready,
  input  wire [23:0] m_axis_tdata,
  output int         fail_count_o,
  output int         pending_o,
  output int         results_o
);

  // bit offsets of the date pair fields in tdata
  localparam int unsigned SMonthLo = dbd_pkg::YearW;
  localparam int unsigned SDayLo   = SMonthLo + dbd_pkg::MonthW;
  localparam int unsigned EYearLo  = SDayLo + dbd_pkg::DayW;
  localparam int unsigned EMonthLo = EYearLo + dbd_pkg::YearW;
  localparam int unsigned EDayLo   = EMonthLo + dbd_pkg::MonthW;

  logic [dbd_pkg::DiffW-1:0] span_q[$];
  logic [dbd_pkg::DiffW-1:0] want;
  int                        fails;

  // days of a common year ahead of month m (1..12)
  function automatic int unsigned month_offset(input int unsigned m);
    int unsigned r;
    case (m)
      1:       r = 0;
      2:       r = 31;
      3:       r = 59;
      4:       r = 90;
      5:       r = 120;
      6:       r = 151;
      7:       r = 181;
      8:       r = 212;
      9:       r = 243;
      10:      r = 273;
      11:      r = 304;
      default: r = 334;
    endcase
    return r;
  endfunction

  // days from the start of year 0 up to and including the given date
  function automatic int unsigned day_number_of(input logic [dbd_pkg::YearW-1:0]  yr,
                                                input logic [dbd_pkg::MonthW-1:0] mo,
                                                input logic [dbd_pkg::DayW-1:0]   dy);
    int unsigned y;
    int unsigned m;
    int unsigned n;
    bit          leap;
    y = yr;
    m = mo;
    if (m < 1) m = 1;
    if (m > 12) m = 12;
    leap = (y % 400 == 0) || ((y % 100 != 0) && (y % 4 == 0));
    n = y * 365 + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400;
    n = n + month_offset(m) + dy;
    if (m > 2 && leap) n = n + 1;
    return n;
  endfunction

  function automatic logic [dbd_pkg::DiffW-1:0] span_of(input logic [47:0] pair);
    int unsigned a;
    int unsigned b;
    int unsigned t;
    a = day_number_of(pair[SMonthLo-1:0], pair[SDayLo-1:SMonthLo],
                      pair[EYearLo-1:SDayLo]);
    b = day_number_of(pair[EMonthLo-1:EYearLo], pair[EDayLo-1:EMonthLo],
                      pair[EDayLo+dbd_pkg::DayW-1:EDayLo]);
    t = b - a;
    return t[dbd_pkg::DiffW-1:0];
  endfunction

  task automatic report_mismatch(input string what);
    $display("%0t ns  MISMATCH  %s", $time, what);
    fails = fails + 1;
    fail_count_o <= fails;
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      span_q.delete();
      pending_o <= 0;
    end else begin
      // results first: a result can never belong to a pair taken this edge
      if (m_axis_tvalid && m_axis_tready) begin
        results_o <= results_o + 1;
        if (span_q.size() == 0) begin
          report_mismatch($sformatf("result %h with nothing outstanding", m_axis_tdata));
        end else begin
          want = span_q.pop_front();
          if (m_axis_tdata[dbd_pkg::DiffW-1:0] !== want)
            report_mismatch($sformatf("day_difference %h, predicted %h",
                                      m_axis_tdata[dbd_pkg::DiffW-1:0], want));
          if (m_axis_tdata[23] !== 1'b0)
            report_mismatch("padding bit of result set");
        end
      end
      if (s_axis_tvalid && s_axis_tready) span_q.push_back(span_of(s_axis_tdata));
      pending_o <= span_q.size();
    end
  end

endmodule

### tb/tb_days_between_dates.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_days_between_dates
// Stream testbench for the date difference block: directed calendar corner
// cases, then random date pairs under three flow-control phases.
// ----------------------------------------------------------------------------
// The checker beside the block predicts every result and counts mismatches;
// this module only generates transactions, shapes back-pressure and gives
// the verdict.
// ----------------------------------------------------------------------------
module tb_days_between_dates;

  localparam int HalfPeriod     = 5;
  localparam int ResetCycles    = 7;
  localparam int BlockLatency   = 3;
  localparam int RandomPerPhase = 650;
  localparam int HoldLen        = 150;     // long output stall, in cycles
  localparam int CycleLimit     = 200000;  // far beyond the slowest run

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic [47:0] s_axis_tdata  = '0;
  logic        m_axis_tready = 1'b0;
  wire         s_axis_tready;
  wire         m_axis_tvalid;
  wire  [23:0] m_axis_tdata;

  int fail_count;
  int pending;
  int results;
  int sent;
  int cycles;
  int tx_idle_pct;     // sender idling, percent of cycles
  int rx_idle_pct;     // receiver idling, percent of cycles
  int hold_reqs;       // bumped by the stimulus to ask for a long stall
  int hold_seen;
  int hold_left;

  always #HalfPeriod clk_i = ~clk_i;

  days_between_dates dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  dbd_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .fail_count_o  (fail_count),
    .pending_o     (pending),
    .results_o     (results)
  );

  // Receiver: random idling, or a long hold-off when one is requested. The
  // hold is counted here so that the sender keeps offering meanwhile and the
  // block fills up and drops s_axis_tready.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      m_axis_tready <= 1'b0;
      hold_left     <= hold_left - 1;
    end else if (hold_reqs != hold_seen) begin
      m_axis_tready <= 1'b0;
      hold_seen     <= hold_reqs;
      hold_left     <= HoldLen;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("watchdog expired after %0d cycles, %0d results outstanding", cycles, pending);
      $display("tb: failure");
      $finish;
    end
  end

  // tdata: [13:0] start_year, [17:14] start_month, [22:18] start_day,
  // [36:23] end_year, [40:37] end_month, [45:41] end_day, [47:46] zero
  function automatic logic [47:0] pack_pair(input int sy, input int sm, input int sd,
                                            input int ey, input int em, input int ed);
    return {2'b00, ed[dbd_pkg::DayW-1:0], em[dbd_pkg::MonthW-1:0], ey[dbd_pkg::YearW-1:0],
            sd[dbd_pkg::DayW-1:0], sm[dbd_pkg::MonthW-1:0], sy[dbd_pkg::YearW-1:0]};
  endfunction

  function automatic int month_len(input int y, input int m);
    int r;
    case (m)
      2:              r = ((y % 400 == 0) || (y % 100 != 0 && y % 4 == 0)) ? 29 : 28;
      4, 6, 9, 11:    r = 30;
      default:        r = 31;
    endcase
    return r;
  endfunction

  // Mostly well-formed dates, some pairs close together (small counts of
  // either sign), some around century leap rules, the rest raw field noise.
  function automatic logic [47:0] random_pair();
    int kind;
    int sy, sm, sd, ey, em, ed;
    kind = $urandom_range(99);
    if (kind >= 90)
      return pack_pair($urandom_range(16383), $urandom_range(15), $urandom_range(31),
                       $urandom_range(16383), $urandom_range(15), $urandom_range(31));
    sm = $urandom_range(1, 12);
    em = $urandom_range(1, 12);
    if (kind < 60) begin
      sy = $urandom_range(1, 9999);
      ey = $urandom_range(1, 9999);
    end else if (kind < 80) begin
      sy = $urandom_range(1, 9999);
      ey = sy + $urandom_range(4) - 2;
    end else begin
      sy = 100 * $urandom_range(1, 99);
      ey = sy + $urandom_range(1) * 4;
      sm = $urandom_range(2, 3);
      em = $urandom_range(2, 3);
    end
    if (ey < 1) ey = 1;
    if (ey > 9999) ey = 9999;
    sd = $urandom_range(1, month_len(sy, sm));
    ed = $urandom_range(1, month_len(ey, em));
    return pack_pair(sy, sm, sd, ey, em, ed);
  endfunction

  // One input transaction; returns at the edge where it was taken.
  task automatic offer_pair(input logic [47:0] pair);
    while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= pair;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sent = sent + 1;
  endtask

  task automatic send_dates(input int sy, input int sm, input int sd,
                            input int ey, input int em, input int ed);
    offer_pair(pack_pair(sy, sm, sd, ey, em, ed));
  endtask

  // Sender stops until every predicted result has come back.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  initial begin
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // phase 1: sender idles 38 %, receiver 67 %
    tx_idle_pct = 38;
    rx_idle_pct <= 67;

    send_dates(2024, 5, 17, 2024, 5, 17);       // same date
    send_dates(1, 1, 1, 9999, 12, 31);          // widest valid span
    send_dates(9999, 12, 31, 1, 1, 1);          // and backwards
    send_dates(2000, 2, 28, 2000, 3, 1);        // leap by the 400 rule
    send_dates(1900, 2, 28, 1900, 3, 1);        // century, common year
    send_dates(2004, 2, 28, 2004, 3, 1);        // leap by the 4 rule
    send_dates(2023, 2, 28, 2023, 3, 1);        // ordinary common year
    send_dates(2021, 1, 1, 2021, 12, 31);
    send_dates(2022, 1, 15, 2022, 7, 15);
    send_dates(2022, 6, 30, 2022, 12, 1);
    send_dates(2020, 0, 5, 2020, 1, 5);         // month zero taken as January
    send_dates(2020, 13, 1, 2020, 15, 1);       // months above 12 taken as December
    send_dates(2020, 12, 1, 2020, 14, 25);
    send_dates(2019, 3, 0, 2019, 2, 28);        // day zero is the day before the 1st
    send_dates(2019, 2, 31, 2019, 3, 3);        // day past month end runs on
    send_dates(2019, 4, 31, 2019, 5, 1);
    send_dates(0, 1, 1, 0, 3, 1);               // year zero is leap
    send_dates(0, 0, 0, 16383, 15, 31);         // all-zero to all-ones, wraps
    send_dates(16383, 15, 31, 0, 0, 0);
    send_dates(9999, 12, 31, 10000, 1, 1);      // beyond year 9999
    send_dates(1600, 12, 31, 1601, 1, 1);

    for (int i = 0; i < RandomPerPhase; i++) begin
      if (i == 200) hold_reqs <= hold_reqs + 1;
      offer_pair(random_pair());
    end
    drain();

    // phase 2: the other way round
    tx_idle_pct = 67;
    rx_idle_pct <= 38;
    for (int i = 0; i < RandomPerPhase; i++) offer_pair(random_pair());
    drain();

    // phase 3: full rate both sides, one long output stall mid-stream
    tx_idle_pct = 0;
    rx_idle_pct <= 0;
    for (int i = 0; i < RandomPerPhase; i++) begin
      if (i == 300) hold_reqs <= hold_reqs + 1;
      offer_pair(random_pair());
    end

    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (BlockLatency * 4) @(posedge clk_i);

    $display("Sent %0d date pairs: calendar corners, out-of-range fields, random spans",
             sent);
    $display("Compared %0d day counts over three idling phases and two long output stalls",
             results);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("tb: failure");
    end
    $finish;
  end

endmodule
